// ===== rtl/core/sbnh_pkg.sv =====
package sbnh_pkg;

  localparam int CoordWidth = 24;
  localparam int OwnerWidth = 16;

  typedef struct packed {
    logic [CoordWidth-1:0] seg_start_x;
    logic [CoordWidth-1:0] seg_start_y;
    logic [CoordWidth-1:0] seg_end_x;
    logic [CoordWidth-1:0] seg_end_y;
    logic [OwnerWidth-1:0] skip_owner;
    logic [CoordWidth-1:0] box_left;
    logic [CoordWidth-1:0] box_top;
    logic [CoordWidth-2:0] box_width;
    logic [CoordWidth-2:0] box_height;
    logic [OwnerWidth-1:0] box_owner;
    logic                  last_box;
  } sbnh_in_t;

  typedef struct packed {
    logic                  hit_found;
    logic [CoordWidth-1:0] hit_x;
    logic [CoordWidth-1:0] hit_y;
    logic [1:0]            hit_edge;
    logic [OwnerWidth-1:0] hit_owner;
  } sbnh_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQW,
    S_CULL,
    S_EDGE,
    S_EMUL,
    S_EMULW,
    S_DIV,
    S_QSQ,
    S_QSQW,
    S_NEXT,
    S_OUT
  } sbnh_state_t;

  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_LEFT   = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_BOTTOM = 2'd3;

endpackage

// ===== rtl/core/sbnh_mul.sv =====
module sbnh_mul #(
  parameter int OpWidth = sbnh_pkg::CoordWidth + 2
) (
  input  logic                   clk,
  input  logic [OpWidth-1:0]     op_a,
  input  logic [OpWidth-1:0]     op_b,
  output logic [2*OpWidth-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== rtl/core/sbnh_div.sv =====
module sbnh_div #(
  parameter int QuoWidth = sbnh_pkg::CoordWidth + 1,
  parameter int DvdWidth = 2 * QuoWidth
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DvdWidth-1:0]     dividend,
  input  logic [QuoWidth-1:0]     divisor,
  output logic                    done,
  output logic [QuoWidth-1:0]     quotient
);
  import sbnh_pkg::*;

  localparam int CntWidth = $clog2(QuoWidth + 1);

  logic [QuoWidth-1:0] rem_r, rem_nxt;
  logic [QuoWidth-1:0] low_r, low_nxt;
  logic [QuoWidth-1:0] quo_r, quo_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [QuoWidth:0]   trial;
  logic                fits;

  assign trial = {rem_r, low_r[QuoWidth-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[2*QuoWidth-1:QuoWidth];
      low_nxt  = dividend[QuoWidth-1:0];
      cnt_nxt  = CntWidth'(QuoWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? QuoWidth'(trial - {1'b0, divisor}) : trial[QuoWidth-1:0];
      low_nxt = {low_r[QuoWidth-2:0], 1'b0};
      quo_nxt = {quo_r[QuoWidth-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/segment_box_nearest_hit.sv =====
// Per box: six differences are squared, then the owner skip and corner cull are checked;
//   otherwise each edge is tested, and a crossed edge adds a multiply, a CoordWidth+1
//   step serial divide and a square. One box at a time: in_ready is high only in idle,
//   so a new box is not taken until the last one is through.
// A result waiting on out_ready holds only the next query's result, not the next box.
// Reset (rst_n low, synchronous) returns to idle, closes the query, drops out_valid.
module segment_box_nearest_hit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbnh_pkg::sbnh_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbnh_pkg::sbnh_out_t out_data
);
  import sbnh_pkg::*;

  localparam int W  = CoordWidth;
  localparam int EW = W + 2;
  localparam int MW = W + 2;
  localparam int PW = 2 * MW;
  localparam int DW = PW + 1;
  localparam int QW = W + 1;
  localparam int RW = W + 3;

  sbnh_state_t state_r, state_nxt;
  sbnh_in_t    in_r;
  sbnh_out_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        open_r, open_nxt;
  logic        bvalid_r, bvalid_nxt;
  logic [DW-1:0] bdist_r, bdist_nxt;
  logic [W-1:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [1:0]    bedge_r, bedge_nxt;
  logic [OwnerWidth-1:0] bown_r, bown_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [1:0]    e_r, e_nxt;
  logic [PW-1:0] sq_r [6];

  logic signed [EW-1:0] sx, sy, ex, ey, x0, y0, x1, y1;
  logic signed [EW-1:0] dif [6];
  logic signed [EW-1:0] a_e, dfix, drun, srun, lo_e, hi_e, fix_e;
  logic                 horiz, ext_zero, cross_ok;
  logic [2:0]           fix_idx;
  logic [MW-1:0]        op_a, op_b;
  logic [PW-1:0]        prod;
  logic                 div_start, div_done;
  logic [QW-1:0]        quo;
  logic signed [RW-1:0] run;
  logic                 neg, in_range;
  logic [DW-1:0]        len, dnew, c00, c10, c01, c11;
  logic                 skip;

  function automatic logic [MW-1:0] mag_f(logic signed [EW-1:0] v);
    return v[EW-1] ? MW'(-v) : MW'(v);
  endfunction

  assign sx = {{2{in_r.seg_start_x[W-1]}}, in_r.seg_start_x};
  assign sy = {{2{in_r.seg_start_y[W-1]}}, in_r.seg_start_y};
  assign ex = {{2{in_r.seg_end_x[W-1]}}, in_r.seg_end_x};
  assign ey = {{2{in_r.seg_end_y[W-1]}}, in_r.seg_end_y};
  assign x0 = {{2{in_r.box_left[W-1]}}, in_r.box_left};
  assign y0 = {{2{in_r.box_top[W-1]}}, in_r.box_top};
  assign x1 = x0 + {3'b000, in_r.box_width};
  assign y1 = y0 + {3'b000, in_r.box_height};

  assign dif[0] = ex - sx;
  assign dif[1] = ey - sy;
  assign dif[2] = x0 - sx;
  assign dif[3] = x1 - sx;
  assign dif[4] = y0 - sy;
  assign dif[5] = y1 - sy;

  always_comb begin
    a_e = dif[4]; fix_e = y0; fix_idx = 3'd4; horiz = 1'b1;
    case (e_r)
      EDGE_TOP:    begin a_e = dif[4]; fix_e = y0; fix_idx = 3'd4; horiz = 1'b1; end
      EDGE_LEFT:   begin a_e = dif[2]; fix_e = x0; fix_idx = 3'd2; horiz = 1'b0; end
      EDGE_RIGHT:  begin a_e = dif[3]; fix_e = x1; fix_idx = 3'd3; horiz = 1'b0; end
      default:     begin a_e = dif[5]; fix_e = y1; fix_idx = 3'd5; horiz = 1'b1; end
    endcase
    dfix     = horiz ? dif[1] : dif[0];
    drun     = horiz ? dif[0] : dif[1];
    srun     = horiz ? sx : sy;
    lo_e     = horiz ? x0 : y0;
    hi_e     = horiz ? x1 : y1;
    ext_zero = horiz ? (in_r.box_width == '0) : (in_r.box_height == '0);
  end

  assign cross_ok = !ext_zero && (dfix != '0) &&
                    (!dfix[EW-1] ? (!a_e[EW-1] && a_e <= dfix)
                                 : (a_e <= 0 && a_e >= dfix));

  assign neg      = (a_e[EW-1] ^ drun[EW-1]) ^ dfix[EW-1];
  assign run      = neg ? (RW'(srun) - RW'({1'b0, quo}))
                        : (RW'(srun) + RW'({1'b0, quo}));
  assign in_range = (run >= RW'(lo_e)) && (run <= RW'(hi_e));
  assign dnew     = DW'(prod) + DW'(sq_r[fix_idx]);

  assign len = DW'(sq_r[0]) + DW'(sq_r[1]);
  assign c00 = DW'(sq_r[2]) + DW'(sq_r[4]);
  assign c10 = DW'(sq_r[3]) + DW'(sq_r[4]);
  assign c01 = DW'(sq_r[2]) + DW'(sq_r[5]);
  assign c11 = DW'(sq_r[3]) + DW'(sq_r[5]);
  assign skip = (in_r.box_owner == in_r.skip_owner) ||
                ((len < c00) && (len < c10) && (len < c01) && (len < c11));

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_SQ:    begin op_a = mag_f(dif[k_r]); op_b = mag_f(dif[k_r]); end
      S_EMUL:  begin op_a = mag_f(a_e); op_b = mag_f(drun); end
      S_QSQ:   begin op_a = MW'(quo); op_b = MW'(quo); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  sbnh_mul #(.OpWidth(MW)) u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  assign div_start = (state_r == S_EMULW);

  sbnh_div #(.QuoWidth(QW), .DvdWidth(2 * QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod[2*QW-1:0]),
    .divisor  (QW'(mag_f(dfix))),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    open_nxt      = open_r;
    bvalid_nxt    = bvalid_r;
    bdist_nxt     = bdist_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    bedge_nxt     = bedge_r;
    bown_nxt      = bown_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt     = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: state_nxt = S_SQW;
      S_SQW: begin
        if (k_r == 3'd5) begin
          state_nxt = S_CULL;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_SQ;
        end
      end
      S_CULL: begin
        if (!open_r) begin
          bdist_nxt  = len;
          bvalid_nxt = 1'b0;
          open_nxt   = 1'b1;
        end
        if (skip) begin
          e_nxt     = EDGE_BOTTOM;
          state_nxt = S_NEXT;
        end else begin
          e_nxt     = EDGE_TOP;
          state_nxt = S_EDGE;
        end
      end
      S_EDGE:  state_nxt = cross_ok ? S_EMUL : S_NEXT;
      S_EMUL:  state_nxt = S_EMULW;
      S_EMULW: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_QSQ;
      S_QSQ:   state_nxt = S_QSQW;
      S_QSQW: begin
        if (in_range && (dnew < bdist_r)) begin
          bdist_nxt  = dnew;
          bvalid_nxt = 1'b1;
          bx_nxt     = horiz ? run[W-1:0] : fix_e[W-1:0];
          by_nxt     = horiz ? fix_e[W-1:0] : run[W-1:0];
          bedge_nxt  = e_r;
          bown_nxt   = in_r.box_owner;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (e_r == EDGE_BOTTOM) begin
          state_nxt = in_r.last_box ? S_OUT : S_IDLE;
        end else begin
          e_nxt     = e_r + 2'd1;
          state_nxt = S_EDGE;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.hit_found = bvalid_r;
          out_nxt.hit_x     = bvalid_r ? bx_r : '0;
          out_nxt.hit_y     = bvalid_r ? by_r : '0;
          out_nxt.hit_edge  = bvalid_r ? bedge_r : EDGE_TOP;
          out_nxt.hit_owner = bvalid_r ? bown_r : '0;
          out_valid_nxt     = 1'b1;
          open_nxt          = 1'b0;
          bvalid_nxt        = 1'b0;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      open_r      <= 1'b0;
      bvalid_r    <= 1'b0;
      k_r         <= '0;
      e_r         <= EDGE_TOP;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      open_r      <= open_nxt;
      bvalid_r    <= bvalid_nxt;
      k_r         <= k_nxt;
      e_r         <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) in_r <= in_data;
    if (state_r == S_SQW) sq_r[k_r] <= prod;
    out_r   <= out_nxt;
    bdist_r <= bdist_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    bedge_r <= bedge_nxt;
    bown_r  <= bown_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/sbnh_checker.sv =====
module sbnh_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input sbnh_pkg::sbnh_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input sbnh_pkg::sbnh_out_t out_data
);
  import sbnh_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit_found |->
      out_data.hit_x == '0 && out_data.hit_y == '0 &&
      out_data.hit_edge == EDGE_TOP && out_data.hit_owner == '0)
    else $error("miss result carries nonzero fields");

  a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while box still in work");

endmodule

bind segment_box_nearest_hit sbnh_checker u_sbnh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/segment_box_nearest_hit_tb.sv =====
`timescale 1ns / 100ps

module segment_box_nearest_hit_tb;
  import sbnh_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sbnh_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  sbnh_out_t out_data;

  segment_box_nearest_hit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sbnh_out_t   hit_queue[$];
  int          errors = 0;
  int          burst_left = 0;

  // predictor state
  longint      near_dsq;
  bit          near_valid;
  longint      near_x;
  longint      near_y;
  logic [1:0]  near_edge;
  logic [15:0] near_owner;
  bit          query_open;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sx24(logic [CoordWidth-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint dsq(longint ax, longint ay);
    return ax * ax + ay * ay;
  endfunction

  function automatic bit edge_cross(longint fixed, longint s_fix, longint d_fix,
                                    longint s_run, longint d_run, longint lo,
                                    longint hi, output longint run);
    longint e_fix, a, mn, mx, q;
    bit neg;
    e_fix = s_fix + d_fix;
    a = fixed - s_fix;
    mn = (s_fix < e_fix) ? s_fix : e_fix;
    mx = (s_fix < e_fix) ? e_fix : s_fix;
    run = 0;
    if (hi == lo || d_fix == 0 || fixed < mn || fixed > mx) return 1'b0;
    q = (mag(a) * mag(d_run)) / mag(d_fix);
    neg = ((a < 0) != (d_run < 0)) != (d_fix < 0);
    run = neg ? s_run - q : s_run + q;
    return run >= lo && run <= hi;
  endfunction

  function automatic void offer(longint ssx, longint ssy, longint x, longint y,
                                logic [1:0] e, logic [15:0] own);
    longint d;
    d = dsq(x - ssx, y - ssy);
    if (d < near_dsq) begin
      near_dsq = d;
      near_valid = 1'b1;
      near_x = x;
      near_y = y;
      near_edge = e;
      near_owner = own;
    end
  endfunction

  function automatic void clear_query();
    near_dsq = 64'sh7fff_ffff_ffff_ffff;
    near_valid = 1'b0;
    near_x = 0;
    near_y = 0;
    near_edge = EDGE_TOP;
    near_owner = '0;
    query_open = 1'b0;
  endfunction

  function automatic void predict_box(sbnh_in_t t);
    longint ssx, ssy, dx, dy, len, x0, y0, x1, y1, r;
    sbnh_out_t res;
    ssx = sx24(t.seg_start_x);
    ssy = sx24(t.seg_start_y);
    dx = sx24(t.seg_end_x) - ssx;
    dy = sx24(t.seg_end_y) - ssy;
    len = dsq(dx, dy);
    if (!query_open) begin
      near_dsq = len;
      near_valid = 1'b0;
      query_open = 1'b1;
    end
    x0 = sx24(t.box_left);
    y0 = sx24(t.box_top);
    x1 = x0 + longint'(t.box_width);
    y1 = y0 + longint'(t.box_height);
    if (t.box_owner != t.skip_owner &&
        !(len < dsq(x0 - ssx, y0 - ssy) && len < dsq(x1 - ssx, y0 - ssy) &&
          len < dsq(x0 - ssx, y1 - ssy) && len < dsq(x1 - ssx, y1 - ssy))) begin
      if (edge_cross(y0, ssy, dy, ssx, dx, x0, x1, r))
        offer(ssx, ssy, r, y0, EDGE_TOP, t.box_owner);
      if (edge_cross(x0, ssx, dx, ssy, dy, y0, y1, r))
        offer(ssx, ssy, x0, r, EDGE_LEFT, t.box_owner);
      if (edge_cross(x1, ssx, dx, ssy, dy, y0, y1, r))
        offer(ssx, ssy, x1, r, EDGE_RIGHT, t.box_owner);
      if (edge_cross(y1, ssy, dy, ssx, dx, x0, x1, r))
        offer(ssx, ssy, r, y1, EDGE_BOTTOM, t.box_owner);
    end
    if (t.last_box) begin
      res.hit_found = near_valid;
      res.hit_x     = near_valid ? near_x[CoordWidth-1:0] : '0;
      res.hit_y     = near_valid ? near_y[CoordWidth-1:0] : '0;
      res.hit_edge  = near_valid ? near_edge : EDGE_TOP;
      res.hit_owner = near_valid ? near_owner : '0;
      hit_queue.insert(hit_queue.size(), res);
      clear_query();
    end
  endfunction

  task automatic send_box(sbnh_in_t t);
    int gap;
    in_data  <= t;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_box(t);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  function automatic sbnh_in_t mk(int sx, int sy, int ex, int ey, int l, int tp,
                                  int w, int h, int own, int skip, bit last);
    sbnh_in_t t;
    t.seg_start_x = CoordWidth'(sx);
    t.seg_start_y = CoordWidth'(sy);
    t.seg_end_x   = CoordWidth'(ex);
    t.seg_end_y   = CoordWidth'(ey);
    t.box_left    = CoordWidth'(l);
    t.box_top     = CoordWidth'(tp);
    t.box_width   = (CoordWidth-1)'(w);
    t.box_height  = (CoordWidth-1)'(h);
    t.box_owner   = OwnerWidth'(own);
    t.skip_owner  = OwnerWidth'(skip);
    t.last_box    = last;
    return t;
  endfunction

  // each edge as the nearest hit, then a box crossed on two of its sides
  task automatic test_each_edge();
    send_box(mk(0, -2560, 0, 2560, -512, -256, 1024, 512, 1, 9, 1));
    send_box(mk(-2560, 0, 2560, 0, -256, -512, 512, 1024, 2, 9, 1));
    send_box(mk(2560, 0, -2560, 0, -256, -512, 512, 1024, 3, 9, 1));
    send_box(mk(0, 2560, 0, -2560, -512, -256, 1024, 512, 4, 9, 1));
    send_box(mk(-2000, -1700, 1900, 2100, -300, -400, 700, 900, 5, 9, 1));
  endtask

  // skipped owner, culled box, nearer later box, equal-distance tie
  task automatic test_skip_cull_tie();
    send_box(mk(0, -2560, 0, 2560, -512, -256, 1024, 512, 7, 7, 1));
    send_box(mk(0, 0, 256, 0, 100000, 100000, 256, 256, 1, 2, 1));
    send_box(mk(0, -2560, 0, 2560, -512, 1000, 1024, 512, 1, 2, 0));
    send_box(mk(0, -2560, 0, 2560, -512, -256, 1024, 512, 3, 2, 1));
    send_box(mk(0, -2560, 0, 2560, -512, -256, 1024, 512, 5, 2, 0));
    send_box(mk(0, -2560, 0, 2560, -512, -256, 1024, 512, 6, 2, 1));
    send_box(mk(0, -1024, 0, 1024, -512, -1024, 1024, 2048, 8, 2, 1));
  endtask

  // zero-size boxes, zero-length segment, segment changed mid query
  task automatic test_degenerate();
    send_box(mk(0, -2560, 0, 2560, -512, -256, 0, 0, 1, 0, 1));
    send_box(mk(0, -2560, 0, 2560, 0, -256, 0, 512, 1, 0, 1));
    send_box(mk(300, 300, 300, 300, 0, 0, 1024, 1024, 1, 0, 1));
    send_box(mk(0, -2560, 0, 2560, -512, 1000, 1024, 512, 1, 0, 0));
    send_box(mk(-2560, 0, 2560, 0, -256, -512, 512, 1024, 2, 0, 1));
  endtask

  // field extremes
  task automatic test_extremes();
    send_box(mk(-8388608, -8388608, 8388607, 8388607, -8388608, -8388608,
                8388607, 8388607, 65535, 0, 1));
    send_box(mk(8388607, -8388608, -8388608, 8388607, 0, 0, 8388607, 0,
                0, 65535, 1));
    send_box(mk(-8388608, 8388607, 8388607, -8388608, -1, -1, 1, 8388607,
                0, 1, 1));
  endtask

  function automatic sbnh_in_t rand_box(int ssx, int ssy, int sex, int sey,
                                        int skip, bit last);
    sbnh_in_t t;
    int span;
    t = mk(ssx, ssy, sex, sey, 0, 0, 0, 0, 0, skip, last);
    if ($urandom_range(0, 9) == 0) begin
      t.box_left   = CoordWidth'($urandom);
      t.box_top    = CoordWidth'($urandom);
      t.box_width  = (CoordWidth-1)'($urandom);
      t.box_height = (CoordWidth-1)'($urandom);
      t.box_owner  = OwnerWidth'($urandom);
    end else begin
      span = $urandom_range(0, 3) == 0 ? 12000 : 3000;
      t.box_left   = CoordWidth'(ssx + $urandom_range(0, 2 * span) - span);
      t.box_top    = CoordWidth'(ssy + $urandom_range(0, 2 * span) - span);
      t.box_width  = $urandom_range(0, 8) == 0 ? '0
                                              : (CoordWidth-1)'($urandom_range(0, span));
      t.box_height = $urandom_range(0, 8) == 0 ? '0
                                              : (CoordWidth-1)'($urandom_range(0, span));
      t.box_owner  = OwnerWidth'($urandom_range(0, 3));
    end
    return t;
  endfunction

  task automatic test_random_queries();
    int sent, n, ssx, ssy, sex, sey, skip;
    sent = 0;
    while (sent < 600) begin
      if ($urandom_range(0, 7) == 0) begin
        ssx = $urandom;
        ssy = $urandom;
        sex = $urandom;
        sey = $urandom;
        skip = $urandom;
      end else begin
        ssx = $urandom_range(0, 32768) - 16384;
        ssy = $urandom_range(0, 32768) - 16384;
        sex = ssx + $urandom_range(0, 8192) - 4096;
        sey = ssy + ($urandom_range(0, 9) == 0 ? 0 : $urandom_range(0, 8192) - 4096);
        skip = $urandom_range(0, 3);
      end
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_box(rand_box(ssx + 256, ssy - 256, sex, sey, skip, i == n - 1));
        else
          send_box(rand_box(ssx, ssy, sex, sey, skip, i == n - 1));
      end
      sent += n;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 3))
        0: out_ready <= 1'b0;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    sbnh_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (hit_queue.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = hit_queue.pop_front();
        if (out_data.hit_found !== want.hit_found) begin
          $error("hit_found exp %0d got %0d", want.hit_found, out_data.hit_found);
          errors++;
        end
        if (out_data.hit_x !== want.hit_x) begin
          $error("hit_x exp %0h got %0h", want.hit_x, out_data.hit_x);
          errors++;
        end
        if (out_data.hit_y !== want.hit_y) begin
          $error("hit_y exp %0h got %0h", want.hit_y, out_data.hit_y);
          errors++;
        end
        if (out_data.hit_edge !== want.hit_edge) begin
          $error("hit_edge exp %0d got %0d", want.hit_edge, out_data.hit_edge);
          errors++;
        end
        if (out_data.hit_owner !== want.hit_owner) begin
          $error("hit_owner exp %0h got %0h", want.hit_owner, out_data.hit_owner);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    clear_query();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_each_edge();
    test_skip_cull_tie();
    test_degenerate();
    test_extremes();
    test_random_queries();
    in_valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && hit_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
